FILE: design/tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

    // Transaction field widths
    localparam int DATA_W      = 32;
    localparam int TERM_CNT_W  = 4;

    // Series length limit and its counter width (limit stays within 1..15)
    localparam int MAX_TERMS   = 8;
    localparam int K_W         = 4;

    // Fixed-point formats
    localparam int FRAC_BITS   = 28;
    localparam int RECIP_BITS  = 32;

    // Shared multiplier: 32x32 digits, two digits per operand
    localparam int DIG_W       = 32;
    localparam int OPND_W      = 2 * DIG_W;
    localparam int PROD_W      = 3 * DIG_W;

    // Magnitude widths, bounded by |x| <= 8 (x^2 <= 64, terms below 512)
    localparam int X2_W        = 36;
    localparam int T_W         = 48;
    localparam int M_W         = 40;
    localparam int ACC_W       = 42;

    // Round-half-up offsets loaded into the product accumulator
    localparam logic [PROD_W-1:0] HALF_Q28 = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] HALF_Q32 = PROD_W'(1) << (RECIP_BITS - 1);

    typedef logic [OPND_W-1:0] opnd_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic start;
        logic a_wide;   // operand a uses its upper digit
        logic b_wide;   // operand b uses its upper digit
        logic q32;      // scale result by 2^-32 instead of 2^-28
    } mul_req_t;

    // Q32 reciprocal of (2k)(2k+1), rounded to nearest
    function automatic logic [RECIP_BITS-1:0] recip(input logic [K_W-1:0] k);
        logic [RECIP_BITS-1:0] r;
        begin
            case (k)
                4'd1:    r = 32'd715827883;
                4'd2:    r = 32'd214748365;
                4'd3:    r = 32'd102261126;
                4'd4:    r = 32'd59652324;
                4'd5:    r = 32'd39045157;
                4'd6:    r = 32'd27531842;
                4'd7:    r = 32'd20452225;
                4'd8:    r = 32'd15790321;
                4'd9:    r = 32'd12558384;
                4'd10:   r = 32'd10226113;
                4'd11:   r = 32'd8488078;
                4'd12:   r = 32'd7158279;
                4'd13:   r = 32'd6118187;
                4'd14:   r = 32'd5289369;
                4'd15:   r = 32'd4618244;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/tse_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module tse_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  tse_pkg::mul_req_t req,
    input  tse_pkg::opnd_t    a,
    input  tse_pkg::opnd_t    b,
    output logic              done,
    output tse_pkg::opnd_t    res
);
    import tse_pkg::*;

    opnd_t             a_reg;
    opnd_t             b_reg;
    logic              a_wide_reg;
    logic              b_wide_reg;
    logic              q32_reg;
    logic              active_reg;
    logic              ai_reg;
    logic              bj_reg;
    logic [OPND_W-1:0] pp_reg;
    logic [1:0]        pp_sh_reg;
    logic              pp_vld_reg;
    logic              pp_last_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [DIG_W-1:0]  a_dig;
    logic [DIG_W-1:0]  b_dig;
    logic [OPND_W-1:0] pp_now;
    logic              step_a;
    logic              step_b;
    logic [PROD_W-1:0] pp_ext;

    // Select the current digit pair and multiply
    assign a_dig  = ai_reg ? a_reg[OPND_W-1:DIG_W] : a_reg[DIG_W-1:0];
    assign b_dig  = bj_reg ? b_reg[OPND_W-1:DIG_W] : b_reg[DIG_W-1:0];
    assign pp_now = {{DIG_W{1'b0}}, a_dig} * {{DIG_W{1'b0}}, b_dig};

    assign step_a = !ai_reg && a_wide_reg;
    assign step_b = !bj_reg && b_wide_reg;

    // Align the registered partial product to its digit weight
    always_comb
    begin
        case (pp_sh_reg)
            2'd1:    pp_ext = {pp_reg, {DIG_W{1'b0}}};
            2'd2:    pp_ext = {pp_reg[DIG_W-1:0], {OPND_W{1'b0}}};
            default: pp_ext = {{DIG_W{1'b0}}, pp_reg};
        endcase
    end

    // Sequence the digit pairs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            ai_reg      <= 1'b0;
            bj_reg      <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            pp_sh_reg   <= '0;
            done_reg    <= 1'b0;
            a_wide_reg  <= 1'b0;
            b_wide_reg  <= 1'b0;
            q32_reg     <= 1'b0;
        end
        else
        begin
            pp_vld_reg  <= active_reg;
            pp_last_reg <= !step_a && !step_b;
            pp_sh_reg   <= {1'b0, ai_reg} + {1'b0, bj_reg};
            done_reg    <= pp_vld_reg && pp_last_reg;
            if (req.start)
            begin
                active_reg <= 1'b1;
                ai_reg     <= 1'b0;
                bj_reg     <= 1'b0;
                a_wide_reg <= req.a_wide;
                b_wide_reg <= req.b_wide;
                q32_reg    <= req.q32;
            end
            else if (active_reg)
            begin
                if (step_a)
                begin
                    ai_reg <= 1'b1;
                end
                else
                begin
                    ai_reg <= 1'b0;
                    if (step_b)
                    begin
                        bj_reg <= 1'b1;
                    end
                    else
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Load operands, register the partial product, accumulate
    always_ff @(posedge clk)
    begin
        pp_reg <= pp_now;
        if (req.start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= req.q32 ? HALF_Q32 : HALF_Q28;
        end
        else if (pp_vld_reg)
        begin
            prod_reg <= prod_reg + pp_ext;
        end
    end

    assign done = done_reg;
    assign res  = q32_reg ? prod_reg[PROD_W-1:RECIP_BITS]
                          : prod_reg[OPND_W+FRAC_BITS-1:FRAC_BITS];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (!active_reg && !pp_vld_reg))
        else $error("multiplier started while a product is in progress");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !active_reg)
        else $error("multiplier done while digit pairs remain");

endmodule

`default_nettype wire

FILE: design/tse_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tse_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [tse_pkg::DATA_W-1:0]     angle_in,
    input  logic [tse_pkg::TERM_CNT_W-1:0]        term_count,
    input  logic                                  out_free,
    output logic                                  idle,
    output logic                                  res_vld,
    output logic [tse_pkg::DATA_W-1:0]            res_val,
    output tse_pkg::mul_req_t                     mul_req,
    output tse_pkg::opnd_t                        mul_a,
    output tse_pkg::opnd_t                        mul_b,
    input  logic                                  mul_done,
    input  tse_pkg::opnd_t                        mul_res
);
    import tse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_X2   = 3'd1;
    localparam logic [2:0] S_X2W  = 3'd2;
    localparam logic [2:0] S_T    = 3'd3;
    localparam logic [2:0] S_TW   = 3'd4;
    localparam logic [2:0] S_M    = 3'd5;
    localparam logic [2:0] S_MW   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-DATA_W+1){1'b0}},
                                                   {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-DATA_W+1){1'b1}},
                                                   {(DATA_W-1){1'b0}}};

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [K_W-1:0]          k_reg;
    logic [K_W-1:0]          n_reg;
    logic                    neg_reg;
    logic [DATA_W-1:0]       mag_reg;
    logic [X2_W-1:0]         x2_reg;
    logic [T_W-1:0]          t_reg;
    logic [M_W-1:0]          m_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [DATA_W-1:0]       mag_in;
    logic [K_W-1:0]          n_in;
    logic [M_W-1:0]          m_new;
    logic signed [ACC_W-1:0] m_ext;
    logic signed [ACC_W-1:0] fin_val;

    // Magnitude and clamped term count of the incoming transaction
    assign mag_in = angle_in[DATA_W-1] ? DATA_W'(~angle_in + 1'b1) : angle_in;
    assign n_in   = (term_count > TERM_CNT_W'(MAX_TERMS)) ? K_W'(MAX_TERMS)
                                                          : K_W'(term_count);

    assign m_new  = mul_res[M_W-1:0];
    assign m_ext  = $signed({{(ACC_W-M_W){1'b0}}, m_new});

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_X2;
            S_X2:    state_next = S_X2W;
            S_X2W:   if (mul_done) state_next = (n_reg == '0) ? S_FIN : S_T;
            S_T:     state_next = S_TW;
            S_TW:    if (mul_done) state_next = S_M;
            S_M:     state_next = S_MW;
            S_MW:    if (mul_done) state_next = (k_reg == n_reg) ? S_FIN : S_T;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                k_reg <= K_W'(1);
                n_reg <= n_in;
            end
            else if (state_reg == S_MW && mul_done)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Capture operands, products and the running sum
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            neg_reg <= angle_in[DATA_W-1];
            mag_reg <= mag_in;
            m_reg   <= M_W'(mag_in);
            acc_reg <= $signed({{(ACC_W-DATA_W){1'b0}}, mag_in});
        end
        if (state_reg == S_X2W && mul_done)
        begin
            x2_reg <= mul_res[X2_W-1:0];
        end
        if (state_reg == S_TW && mul_done)
        begin
            t_reg <= mul_res[T_W-1:0];
        end
        if (state_reg == S_MW && mul_done)
        begin
            m_reg   <= m_new;
            acc_reg <= k_reg[0] ? (acc_reg - m_ext) : (acc_reg + m_ext);
        end
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_X2:
            begin
                mul_req.start = 1'b1;
                mul_a         = OPND_W'(mag_reg);
                mul_b         = OPND_W'(mag_reg);
            end
            S_T:
            begin
                mul_req.start  = 1'b1;
                mul_req.a_wide = 1'b1;
                mul_req.b_wide = 1'b1;
                mul_a          = OPND_W'(m_reg);
                mul_b          = OPND_W'(x2_reg);
            end
            S_M:
            begin
                mul_req.start  = 1'b1;
                mul_req.a_wide = 1'b1;
                mul_req.q32    = 1'b1;
                mul_a          = OPND_W'(t_reg);
                mul_b          = OPND_W'(recip(k_reg));
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Apply the sign and saturate
    assign fin_val = neg_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        if (fin_val > SAT_MAX)
        begin
            res_val = SAT_MAX[DATA_W-1:0];
        end
        else if (fin_val < SAT_MIN)
        begin
            res_val = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            res_val = fin_val[DATA_W-1:0];
        end
    end

    assign res_vld = (state_reg == S_FIN) && out_free;
    assign idle    = (state_reg == S_IDLE);

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T || state_reg == S_M) |-> (k_reg != '0 && k_reg <= n_reg))
        else $error("term index outside the requested series length");

endmodule

`default_nettype wire

FILE: design/taylor_sine_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Truncated Taylor-series sine of a signed Q3.28 angle, result signed Q3.28 and
// saturated. One transaction is processed at a time. The series adds n terms
// after x, where n is term_count clamped to 8 (term_count resets to 3). All
// products go through the single shared 32x32 multiplier: x^2 takes one partial
// product, each term then takes four partial products for the multiply by x^2
// and two for the multiply by the reciprocal table entry. Every multiply has an
// issue step before its partial products and an accumulate and a hand-back step
// after them, and a final step moves the result into the output register. The next
// angle is taken as soon as the result has moved into the output register, even
// if it has not yet been read.
// term_count is written through cfg_we / cfg_wdata; write it only while no
// transaction is open. The block itself does not enforce this.
module taylor_sine_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tse_pkg::TERM_CNT_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tse_pkg::DATA_W-1:0]   angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tse_pkg::DATA_W-1:0]   sine
);
    import tse_pkg::*;

    logic [TERM_CNT_W-1:0] term_count_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     sine_reg;

    logic                  seq_idle;
    logic                  seq_res_vld;
    logic [DATA_W-1:0]     seq_res_val;
    logic                  out_free;
    logic                  in_take;
    mul_req_t              mul_req;
    opnd_t                 mul_a;
    opnd_t                 mul_b;
    logic                  mul_done;
    opnd_t                 mul_res;

    assign in_stall = !seq_idle;
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Hold the term count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_CNT_W'(3);
        end
        else if (cfg_we)
        begin
            term_count_reg <= cfg_wdata;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res_vld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_vld)
        begin
            sine_reg <= seq_res_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = $signed(sine_reg);

    tse_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_take),
        .angle_in   (angle),
        .term_count (term_count_reg),
        .out_free   (out_free),
        .idle       (seq_idle),
        .res_vld    (seq_res_vld),
        .res_val    (seq_res_val),
        .mul_req    (mul_req),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_done   (mul_done),
        .mul_res    (mul_res)
    );

    tse_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_res_vld |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an unread transaction");

endmodule

`default_nettype wire
